>>> sv/opbg_pkg.sv
// Package: shared types, codes and constants of the output pulse/blink generator
package opbg_pkg;

   localparam int unsigned CHANNELS_DEFAULT = 16;
   localparam int unsigned CNT_W = 17;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   typedef enum logic [3:0] {
      OP_TICK        = 4'd0,
      OP_SET_NOW     = 4'd1,
      OP_SET         = 4'd2,
      OP_SET_DLY     = 4'd3,
      OP_TOG_NOW     = 4'd4,
      OP_TOG         = 4'd5,
      OP_TOG_DLY     = 4'd6,
      OP_PULSE_NOW   = 4'd7,
      OP_PULSE       = 4'd8,
      OP_PULSE_DLY   = 4'd9,
      OP_BLINK_NOW   = 4'd10,
      OP_BLINK       = 4'd11,
      OP_BLINK_FOR   = 4'd12
   } op_type;

   typedef enum logic [2:0] {
      MODE_SET       = 3'd0,
      MODE_SET_DLY   = 3'd1,
      MODE_TOG       = 3'd2,
      MODE_TOG_DLY   = 3'd3,
      MODE_PULSE     = 3'd4,
      MODE_PULSE_DLY = 3'd5,
      MODE_BLINK     = 3'd6,
      MODE_BLINK_FOR = 3'd7
   } mode_type;

   typedef enum logic [0:0] {
      ST_IDLE = 1'b0,
      ST_HOLD = 1'b1
   } state_type;

   typedef struct packed {
      logic [3:0]  operation;
      logic [3:0]  channel;
      logic        level;
      logic [15:0] period_ticks;
      logic [15:0] duration_ticks;
   } req_type;

   typedef struct packed {
      logic [15:0] pin_levels;
      logic [15:0] busy_mask;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic apply;
   } cmd_type;

endpackage

>>> sv/opbg_datapath.sv
// Datapath: per-channel state registers, tick and command update, result register
module opbg_datapath #(
   parameter int unsigned CHANNELS = opbg_pkg::CHANNELS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  opbg_pkg::cmd_type cmd,
   input  opbg_pkg::req_type req,
   output opbg_pkg::rsp_type rsp
);

   localparam int unsigned CW = opbg_pkg::CNT_W;

   logic [CHANNELS-1:0] act_ff, act_in, lvl_ff, lvl_in, tgt_ff, tgt_in;
   opbg_pkg::mode_type  mode_ff [CHANNELS];
   opbg_pkg::mode_type  mode_in [CHANNELS];
   logic [15:0]         per_ff  [CHANNELS];
   logic [15:0]         per_in  [CHANNELS];
   logic [15:0]         dur_ff  [CHANNELS];
   logic [15:0]         dur_in  [CHANNELS];
   logic [CW-1:0]       pc_ff   [CHANNELS];
   logic [CW-1:0]       pc_in   [CHANNELS];
   logic [CW-1:0]       dc_ff   [CHANNELS];
   logic [CW-1:0]       dc_in   [CHANNELS];
   opbg_pkg::rsp_type   rsp_ff, rsp_in;

   always_comb begin
      logic [CW-1:0] pcn, dcn;
      logic          hit, do_pulse;
      for (int c = 0; c < CHANNELS; c++) begin
         act_in[c]  = act_ff[c];
         lvl_in[c]  = lvl_ff[c];
         tgt_in[c]  = tgt_ff[c];
         mode_in[c] = mode_ff[c];
         per_in[c]  = per_ff[c];
         dur_in[c]  = dur_ff[c];
         pc_in[c]   = pc_ff[c];
         dc_in[c]   = dc_ff[c];
         pcn = (pc_ff[c] == opbg_pkg::CNT_MAX) ? pc_ff[c] : pc_ff[c] + 1'b1;
         dcn = (dc_ff[c] == opbg_pkg::CNT_MAX) ? dc_ff[c] : dc_ff[c] + 1'b1;
         hit = dcn > {1'b0, dur_ff[c]};
         do_pulse = 1'b0;
         if (!cmd.apply) begin
         end else if (req.operation == opbg_pkg::OP_TICK) begin
            if (act_ff[c]) begin
               pc_in[c] = pcn;
               dc_in[c] = dcn;
               case (mode_ff[c])
                  opbg_pkg::MODE_SET: begin
                     lvl_in[c] = tgt_ff[c];
                     act_in[c] = 1'b0;
                  end
                  opbg_pkg::MODE_TOG: begin
                     lvl_in[c] = ~lvl_ff[c];
                     act_in[c] = 1'b0;
                  end
                  opbg_pkg::MODE_SET_DLY, opbg_pkg::MODE_TOG_DLY: begin
                     if (hit) begin
                        lvl_in[c] = (mode_ff[c] == opbg_pkg::MODE_SET_DLY) ?
                                    tgt_ff[c] : ~lvl_ff[c];
                        dc_in[c]  = '0;
                        act_in[c] = 1'b0;
                     end
                  end
                  opbg_pkg::MODE_PULSE:     do_pulse = 1'b1;
                  opbg_pkg::MODE_PULSE_DLY: do_pulse = hit;
                  opbg_pkg::MODE_BLINK: begin
                     if (pcn > {1'b0, per_ff[c]}) begin
                        lvl_in[c] = ~lvl_ff[c];
                        pc_in[c]  = '0;
                        dc_in[c]  = '0;
                     end
                  end
                  opbg_pkg::MODE_BLINK_FOR: begin
                     if ({1'b0, dur_ff[c]} > dcn) begin
                        if (pcn > {1'b0, per_ff[c]}) begin
                           lvl_in[c] = ~lvl_ff[c];
                           pc_in[c]  = '0;
                        end
                     end else begin
                        lvl_in[c] = tgt_ff[c];
                        pc_in[c]  = '0;
                        dc_in[c]  = '0;
                        act_in[c] = 1'b0;
                     end
                  end
                  default: act_in[c] = 1'b0;
               endcase
               if (do_pulse) begin
                  if (tgt_ff[c] != lvl_ff[c]) begin
                     lvl_in[c] = tgt_ff[c];
                     pc_in[c]  = '0;
                  end else if (pcn > {1'b0, per_ff[c]}) begin
                     lvl_in[c] = ~lvl_ff[c];
                     pc_in[c]  = '0;
                     dc_in[c]  = '0;
                     act_in[c] = 1'b0;
                  end
               end
            end
         end else if (32'(req.channel) == c && req.operation <= opbg_pkg::OP_BLINK_FOR) begin
            pc_in[c]  = '0;
            dc_in[c]  = '0;
            per_in[c] = '0;
            dur_in[c] = '0;
            act_in[c] = 1'b1;
            case (req.operation)
               opbg_pkg::OP_SET_NOW: begin
                  mode_in[c] = opbg_pkg::MODE_SET;
                  act_in[c]  = 1'b0;
                  lvl_in[c]  = req.level;
                  tgt_in[c]  = req.level;
               end
               opbg_pkg::OP_SET: begin
                  mode_in[c] = opbg_pkg::MODE_SET;
                  tgt_in[c]  = req.level;
               end
               opbg_pkg::OP_SET_DLY: begin
                  mode_in[c] = opbg_pkg::MODE_SET_DLY;
                  dur_in[c]  = req.duration_ticks;
                  tgt_in[c]  = req.level;
               end
               opbg_pkg::OP_TOG_NOW: begin
                  mode_in[c] = opbg_pkg::MODE_TOG;
                  act_in[c]  = 1'b0;
                  lvl_in[c]  = ~lvl_ff[c];
                  tgt_in[c]  = ~lvl_ff[c];
               end
               opbg_pkg::OP_TOG: mode_in[c] = opbg_pkg::MODE_TOG;
               opbg_pkg::OP_TOG_DLY: begin
                  mode_in[c] = opbg_pkg::MODE_TOG_DLY;
                  dur_in[c]  = req.duration_ticks;
               end
               opbg_pkg::OP_PULSE_NOW: begin
                  mode_in[c] = opbg_pkg::MODE_PULSE;
                  per_in[c]  = req.period_ticks;
                  lvl_in[c]  = ~lvl_ff[c];
                  tgt_in[c]  = ~lvl_ff[c];
               end
               opbg_pkg::OP_PULSE: begin
                  mode_in[c] = opbg_pkg::MODE_PULSE;
                  per_in[c]  = req.period_ticks;
                  tgt_in[c]  = ~lvl_ff[c];
               end
               opbg_pkg::OP_PULSE_DLY: begin
                  mode_in[c] = opbg_pkg::MODE_PULSE_DLY;
                  per_in[c]  = req.period_ticks;
                  dur_in[c]  = req.duration_ticks;
                  tgt_in[c]  = ~lvl_ff[c];
               end
               opbg_pkg::OP_BLINK_NOW: begin
                  mode_in[c] = opbg_pkg::MODE_BLINK;
                  per_in[c]  = req.period_ticks;
                  lvl_in[c]  = 1'b1;
               end
               opbg_pkg::OP_BLINK: begin
                  mode_in[c] = opbg_pkg::MODE_BLINK;
                  per_in[c]  = req.period_ticks;
               end
               opbg_pkg::OP_BLINK_FOR: begin
                  mode_in[c] = opbg_pkg::MODE_BLINK_FOR;
                  per_in[c]  = req.period_ticks;
                  dur_in[c]  = req.duration_ticks;
                  tgt_in[c]  = req.level;
               end
               default: act_in[c] = act_ff[c];
            endcase
         end
      end
      rsp_in = '0;
      for (int c = 0; c < CHANNELS && c < 16; c++) begin
         rsp_in.pin_levels[c] = lvl_in[c];
         rsp_in.busy_mask[c]  = act_in[c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= '0;
         lvl_ff <= '0;
         tgt_ff <= '0;
         for (int c = 0; c < CHANNELS; c++) begin
            mode_ff[c] <= opbg_pkg::MODE_SET;
            per_ff[c]  <= '0;
            dur_ff[c]  <= '0;
            pc_ff[c]   <= '0;
            dc_ff[c]   <= '0;
         end
      end else begin
         act_ff <= act_in;
         lvl_ff <= lvl_in;
         tgt_ff <= tgt_in;
         for (int c = 0; c < CHANNELS; c++) begin
            mode_ff[c] <= mode_in[c];
            per_ff[c]  <= per_in[c];
            dur_ff[c]  <= dur_in[c];
            pc_ff[c]   <= pc_in[c];
            dc_ff[c]   <= dc_in[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

>>> sv/opbg_ctrl.sv
// Controller: handshake state machine, holds a result until it is transferred
module opbg_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output opbg_pkg::cmd_type cmd
);

   opbg_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= opbg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      rsp_valid = 1'b0;
      req_stall = 1'b0;
      case (state_ff)
         opbg_pkg::ST_IDLE: begin
            if (req_valid) state_in = opbg_pkg::ST_HOLD;
         end
         opbg_pkg::ST_HOLD: begin
            rsp_valid = 1'b1;
            // next item may enter as the result leaves
            req_stall = rsp_stall;
            if (!rsp_stall && !req_valid) state_in = opbg_pkg::ST_IDLE;
         end
         default: state_in = opbg_pkg::ST_IDLE;
      endcase
      cmd.apply = req_valid && !req_stall;
   end

endmodule

>>> sv/output_pulse_blink_generator.sv
// Top level: output pulse/blink generator
// Result: valid in the cycle after an item transfer.
// Throughput: one item per cycle while the result side does not stall;
//   every channel updates in parallel on a tick.
// Reset: synchronous, all pins low, all channels idle, set mode.
module output_pulse_blink_generator #(
   parameter int unsigned CHANNELS = opbg_pkg::CHANNELS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  opbg_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output opbg_pkg::rsp_type rsp_data
);

   opbg_pkg::cmd_type cmd;

   // controller owns the handshake, datapath owns channel state
   opbg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   opbg_datapath #(.CHANNELS(CHANNELS)) u_dp (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .req   (req_data),
      .rsp   (rsp_data)
   );

endmodule

>>> sv/opbg_checker.sv
// Checker: port-level properties of the generator, bound to the top level
module opbg_props (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input opbg_pkg::rsp_type rsp_data
);

   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid) else $error("no result after transfer");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_stall_only_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall) else $error("spurious input stall");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !req_valid |=> !rsp_valid) else $error("result without transfer");

endmodule

bind output_pulse_blink_generator opbg_props u_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

>>> tb/opbg_checker.sv
// Checker: watches all 16 channels, predicts pin levels and busy mask, compares
module opbg_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  opbg_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  opbg_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NCH = 16;
   localparam logic [16:0] SAT = '1;

   opbg_pkg::mode_type mode [NCH];
   logic               active [NCH];
   logic               lvl [NCH];
   logic               target [NCH];
   logic [15:0]        per [NCH];
   logic [15:0]        dur [NCH];
   logic [16:0]        pcnt [NCH];
   logic [16:0]        dcnt [NCH];
   opbg_pkg::rsp_type  pin_queue [$];

   function automatic logic [16:0] bump(logic [16:0] v);
      return (v == SAT) ? v : v + 17'd1;
   endfunction

   function automatic void load(int c, opbg_pkg::mode_type m, logic a,
                                logic [15:0] p, logic [15:0] d);
      mode[c] = m; active[c] = a; per[c] = p; dur[c] = d; pcnt[c] = '0; dcnt[c] = '0;
   endfunction

   function automatic void pulse_step(int c);
      if (target[c] != lvl[c]) begin
         lvl[c] = target[c];
         pcnt[c] = '0;
      end else if (pcnt[c] > {1'b0, per[c]}) begin
         lvl[c] = ~lvl[c]; pcnt[c] = '0; dcnt[c] = '0; active[c] = 1'b0;
      end
   endfunction

   function automatic void advance(int c);
      if (!active[c]) return;
      pcnt[c] = bump(pcnt[c]);
      dcnt[c] = bump(dcnt[c]);
      case (mode[c])
         opbg_pkg::MODE_SET: begin lvl[c] = target[c]; active[c] = 1'b0; end
         opbg_pkg::MODE_TOG: begin lvl[c] = ~lvl[c]; active[c] = 1'b0; end
         opbg_pkg::MODE_SET_DLY, opbg_pkg::MODE_TOG_DLY: begin
            if (dcnt[c] > {1'b0, dur[c]}) begin
               lvl[c] = (mode[c] == opbg_pkg::MODE_SET_DLY) ? target[c] : ~lvl[c];
               dcnt[c] = '0; active[c] = 1'b0;
            end
         end
         opbg_pkg::MODE_PULSE: pulse_step(c);
         opbg_pkg::MODE_PULSE_DLY: if (dcnt[c] > {1'b0, dur[c]}) pulse_step(c);
         opbg_pkg::MODE_BLINK: begin
            if (pcnt[c] > {1'b0, per[c]}) begin
               lvl[c] = ~lvl[c]; pcnt[c] = '0; dcnt[c] = '0;
            end
         end
         default: begin // blink for a duration
            if ({1'b0, dur[c]} > dcnt[c]) begin
               if (pcnt[c] > {1'b0, per[c]}) begin
                  lvl[c] = ~lvl[c]; pcnt[c] = '0;
               end
            end else begin
               lvl[c] = target[c]; pcnt[c] = '0; dcnt[c] = '0; active[c] = 1'b0;
            end
         end
      endcase
   endfunction

   function automatic opbg_pkg::rsp_type predict_pins(opbg_pkg::req_type r);
      opbg_pkg::rsp_type o;
      int c;
      c = int'(r.channel);
      case (r.operation)
         opbg_pkg::OP_TICK: for (int i = 0; i < NCH; i++) advance(i);
         opbg_pkg::OP_SET_NOW: begin
            load(c, opbg_pkg::MODE_SET, 1'b0, 16'd0, 16'd0);
            lvl[c] = r.level; target[c] = r.level;
         end
         opbg_pkg::OP_SET: begin
            load(c, opbg_pkg::MODE_SET, 1'b1, 16'd0, 16'd0); target[c] = r.level;
         end
         opbg_pkg::OP_SET_DLY: begin
            load(c, opbg_pkg::MODE_SET_DLY, 1'b1, 16'd0, r.duration_ticks);
            target[c] = r.level;
         end
         opbg_pkg::OP_TOG_NOW: begin
            load(c, opbg_pkg::MODE_TOG, 1'b0, 16'd0, 16'd0);
            lvl[c] = ~lvl[c]; target[c] = lvl[c];
         end
         opbg_pkg::OP_TOG: load(c, opbg_pkg::MODE_TOG, 1'b1, 16'd0, 16'd0);
         opbg_pkg::OP_TOG_DLY:
            load(c, opbg_pkg::MODE_TOG_DLY, 1'b1, 16'd0, r.duration_ticks);
         opbg_pkg::OP_PULSE_NOW: begin
            load(c, opbg_pkg::MODE_PULSE, 1'b1, r.period_ticks, 16'd0);
            lvl[c] = ~lvl[c]; target[c] = lvl[c];
         end
         opbg_pkg::OP_PULSE: begin
            load(c, opbg_pkg::MODE_PULSE, 1'b1, r.period_ticks, 16'd0);
            target[c] = ~lvl[c];
         end
         opbg_pkg::OP_PULSE_DLY: begin
            load(c, opbg_pkg::MODE_PULSE_DLY, 1'b1, r.period_ticks, r.duration_ticks);
            target[c] = ~lvl[c];
         end
         opbg_pkg::OP_BLINK_NOW: begin
            load(c, opbg_pkg::MODE_BLINK, 1'b1, r.period_ticks, 16'd0); lvl[c] = 1'b1;
         end
         opbg_pkg::OP_BLINK: load(c, opbg_pkg::MODE_BLINK, 1'b1, r.period_ticks, 16'd0);
         opbg_pkg::OP_BLINK_FOR: begin
            load(c, opbg_pkg::MODE_BLINK_FOR, 1'b1, r.period_ticks, r.duration_ticks);
            target[c] = r.level;
         end
         default: ; // unused codes leave everything as it is
      endcase
      for (int i = 0; i < NCH; i++) begin
         o.pin_levels[i] = lvl[i];
         o.busy_mask[i] = active[i];
      end
      return o;
   endfunction

   always @(posedge clock) begin
      opbg_pkg::rsp_type want;
      if (reset) begin
         for (int i = 0; i < NCH; i++) begin
            load(i, opbg_pkg::MODE_SET, 1'b0, 16'd0, 16'd0);
            lvl[i] = 1'b0; target[i] = 1'b0;
         end
         pin_queue.delete();
         fail_count <= 0;
      end else begin
         if (req_valid && !req_stall) pin_queue.push_back(predict_pins(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (pin_queue.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = pin_queue.pop_front();
               if (want.pin_levels !== rsp_data.pin_levels
                   || want.busy_mask !== rsp_data.busy_mask) begin
                  $display("%0t: mismatch pins exp %h got %h, busy exp %h got %h", $time,
                           want.pin_levels, rsp_data.pin_levels, want.busy_mask,
                           rsp_data.busy_mask);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending = pin_queue.size();
   end
endmodule

>>> tb/tb.sv
// Testbench top: stimulus, handshake pressure and verdict for the pulse/blink generator
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1530;
   localparam int CYCLE_LIMIT  = 400000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   opbg_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   opbg_pkg::rsp_type rsp_data;
   int                fail_count;
   int                pending;
   int                cycles = 0;
   bit                quiet_tail = 0;   // no idling on either side near the end
   bit                hold_long = 0;    // request a long receiver hold-off

   always #6 clock = ~clock;

   output_pulse_blink_generator dut (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data
   );

   opbg_checker checker_i (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .fail_count, .pending
   );

   // Watchdog on total run length
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Receiver: random stall bursts, plus one long hold-off so the block backs up
   initial begin
      int n;
      repeat (7) @(negedge clock);
      forever begin
         if (hold_long) begin
            rsp_stall <= 1'b1;
            repeat (60) @(negedge clock);
            hold_long = 0;
         end else if (!quiet_tail && $urandom_range(3) == 0) begin
            rsp_stall <= 1'b1;
            n = $urandom_range(19, 1);
            repeat (n) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
            n = $urandom_range(30, 1);
            repeat (n) @(negedge clock);
         end
      end
   end

   // One transfer: hold valid and payload until accepted
   task automatic send_item(opbg_pkg::req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic maybe_gap();
      int n;
      if (!quiet_tail && $urandom_range(7) == 0) begin
         req_valid <= 1'b0;
         n = $urandom_range(19, 1);
         repeat (n) @(negedge clock);
      end
   endtask

   function automatic opbg_pkg::req_type make_cmd(opbg_pkg::op_type op, int ch, logic lv,
                                                  int p, int d);
      opbg_pkg::req_type r;
      r.operation = op; r.channel = 4'(ch); r.level = lv;
      r.period_ticks = 16'(p); r.duration_ticks = 16'(d);
      return r;
   endfunction

   // Mostly small periods so timed actions finish; occasionally any 16-bit value
   function automatic logic [15:0] pick_ticks();
      int s;
      s = $urandom_range(99);
      if (s < 80) return 16'($urandom_range(6));
      if (s < 95) return 16'($urandom_range(40));
      return 16'($urandom);
   endfunction

   initial begin
      opbg_pkg::req_type r;
      int s;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Directed: every operation, field extremes, ignored codes
      send_item(make_cmd(opbg_pkg::OP_SET_NOW, 0, 1, 16'hFFFF, 16'hFFFF));
      send_item(make_cmd(opbg_pkg::OP_SET, 15, 1, 0, 0));
      send_item(make_cmd(opbg_pkg::OP_SET_DLY, 1, 1, 0, 2));
      send_item(make_cmd(opbg_pkg::OP_TOG_NOW, 2, 0, 0, 0));
      send_item(make_cmd(opbg_pkg::OP_TOG, 3, 0, 0, 0));
      send_item(make_cmd(opbg_pkg::OP_TOG_DLY, 4, 0, 0, 1));
      send_item(make_cmd(opbg_pkg::OP_PULSE_NOW, 5, 0, 1, 0));
      send_item(make_cmd(opbg_pkg::OP_PULSE, 6, 0, 0, 0));
      send_item(make_cmd(opbg_pkg::OP_PULSE_DLY, 7, 0, 1, 2));
      send_item(make_cmd(opbg_pkg::OP_BLINK_NOW, 8, 0, 0, 0));
      send_item(make_cmd(opbg_pkg::OP_BLINK, 9, 0, 1, 0));
      send_item(make_cmd(opbg_pkg::OP_BLINK_FOR, 10, 1, 0, 5));
      send_item(make_cmd(opbg_pkg::OP_BLINK_FOR, 11, 0, 16'hFFFF, 16'hFFFF));
      r = '1; send_item(r);              // unused code 15, all bits high
      r.operation = 4'd13; send_item(r); // another unused code
      repeat (8) send_item(make_cmd(opbg_pkg::OP_TICK, 0, 0, 0, 0));

      // Long receiver hold-off while items keep coming
      hold_long = 1;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS - 150) quiet_tail = 1;
         if (i == 600) begin
            // sender pauses until every expected result is back
            req_valid <= 1'b0;
            while (pending != 0) @(negedge clock);
         end
         s = $urandom_range(99);
         r.channel = 4'($urandom);
         r.level = 1'($urandom);
         r.period_ticks = pick_ticks();
         r.duration_ticks = pick_ticks();
         if (s < 55) r.operation = opbg_pkg::OP_TICK;
         else if (s < 97) r.operation = 4'($urandom_range(12, 1));
         else r.operation = 4'($urandom_range(15, 13));
         send_item(r);
         maybe_gap();
      end
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

>>> filelist.f
sv/opbg_pkg.sv
sv/opbg_datapath.sv
sv/opbg_ctrl.sv
sv/output_pulse_blink_generator.sv
sv/opbg_checker.sv
tb/opbg_checker.sv
tb/tb.sv
